// ===== design/wsfr_pkg.sv =====
// Shared types and constants of the websocket frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package wsfr_pkg;

  localparam int unsigned CFG_W    = 21;
  localparam int unsigned LEN_W    = 21;
  localparam int unsigned CNT_W    = 4;

  localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 21'd8192;
  localparam logic [LEN_W:0]   MASK_KEY_BYTES  = 22'd4;

  localparam logic [7:0] HDR_BYTE0   = 8'h82;
  localparam logic [7:0] LEN16_CODE  = 8'hFE;
  localparam logic [7:0] LEN64_CODE  = 8'hFF;
  localparam logic [CNT_W-1:0] LEN16_BYTES = 4'd2;
  localparam logic [CNT_W-1:0] LEN64_BYTES = 4'd8;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_LEN,
    PH_MASK,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_EMPTY,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_FIRST,
    ERR_NOMASK,
    ERR_LONG
  } err_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    err_t       err;
  } res_t;

endpackage

`default_nettype wire

// ===== design/websocket_frame_receiver_core.sv =====
// Top level of the websocket binary frame receiver.
// Takes one received byte per request and parses masked binary websocket frames (0x82 header,
// mask bit required, 7-, 16- or 64-bit length, four-byte mask key), giving one unmasked
// payload byte per payload request, with out_tlast on the frame's last byte. A zero-length
// frame gives one empty-frame result on its fourth mask byte; a bad header or a length whose
// payload plus four key bytes exceeds max_frame_bytes gives one error result, and every byte
// after an error is taken and dropped until reset. Throughput is one byte per cycle: a byte is
// taken in any cycle in which the output register is empty or being drained, and its result
// is registered, the parser state updating in a single registered step per byte.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_receiver_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire  [7:0]                  in_tdata,   // rx_byte
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [7:0]                  out_tdata,  // out_byte
  output logic [3:0]                  out_tuser,  // out_kind[1:0], error_kind[3:2]
  output logic                        out_tlast,  // frame_end
  input  wire                         cfg_we,
  input  wire  [wsfr_pkg::CFG_W-1:0]  cfg_wdata   // max_frame_bytes
);
  import wsfr_pkg::*;

  logic [CFG_W-1:0] max_frame_r;
  logic             in_acc;
  res_t             res;
  res_t             out_r;

  assign in_tready = !out_r.valid || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= MAX_FRAME_RESET;
    end else if (cfg_we) begin
      max_frame_r <= cfg_wdata;
    end
  end

  wsfr_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_acc),
    .in_byte         (in_tdata),
    .max_frame_bytes (max_frame_r),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (in_acc && res.valid) begin
      out_r <= res;
    end else if (out_tready) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_tvalid = out_r.valid;
  assign out_tdata  = out_r.data;
  assign out_tuser  = {out_r.err, out_r.kind};
  assign out_tlast  = out_r.last;

endmodule

`default_nettype wire

// ===== design/wsfr_parser.sv =====
// Frame header parser, length check and payload unmasking.
`timescale 1ns / 1ps
`default_nettype none

module wsfr_parser (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         accept,
  input  wire  [7:0]                  in_byte,
  input  wire  [wsfr_pkg::CFG_W-1:0]  max_frame_bytes,
  output wsfr_pkg::res_t              res
);
  import wsfr_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] payload_r, payload_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             halted_r, halted_nxt;

  logic             act;
  logic             hdr1_short;
  logic [LEN_W-1:0] acc_shift;
  logic             ovf_shift;
  logic [CNT_W-1:0] left_dec;
  logic             len_last;
  logic [LEN_W-1:0] chk_len;
  logic             chk_ovf;
  logic             too_long;
  logic             err_first, err_nomask, err_long;
  logic             mask_done;
  logic             data_last;
  logic [7:0]       key_byte;

  assign act        = accept && !halted_r;
  assign hdr1_short = in_byte[7] && (in_byte != LEN64_CODE) && (in_byte != LEN16_CODE);

  // Only 21 bits of length are kept; anything shifted out above them is sticky overflow.
  assign acc_shift  = {acc_r[LEN_W-9:0], in_byte};
  assign ovf_shift  = ovf_r | (|acc_r[LEN_W-1:LEN_W-8]);
  assign left_dec   = (left_r != '0) ? left_r - 1'b1 : left_r;
  assign len_last   = (left_dec == '0);

  assign chk_len  = (phase_r == PH_HDR1) ? {{(LEN_W-7){1'b0}}, in_byte[6:0]} : acc_shift;
  assign chk_ovf  = (phase_r == PH_HDR1) ? 1'b0 : ovf_shift;
  assign too_long = chk_ovf || (({1'b0, chk_len} + MASK_KEY_BYTES) > {1'b0, max_frame_bytes});

  assign err_first  = act && (phase_r == PH_HDR0) && (in_byte != HDR_BYTE0);
  assign err_nomask = act && (phase_r == PH_HDR1) && !in_byte[7];
  assign err_long   = act && too_long &&
                      (((phase_r == PH_HDR1) && hdr1_short) || ((phase_r == PH_LEN) && len_last));

  assign mask_done  = (idx_r == 2'd3);
  assign data_last  = (payload_r <= {{(LEN_W-1){1'b0}}, 1'b1});

  always_comb begin
    unique case (idx_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      2'd3: key_byte = key_r[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    left_nxt    = left_r;
    payload_nxt = payload_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    halted_nxt  = halted_r;
    if (err_first || err_nomask || err_long) begin
      halted_nxt = 1'b1;
    end else if (act) begin
      unique case (phase_r)
        PH_HDR0: phase_nxt = PH_HDR1;
        PH_HDR1: begin
          acc_nxt = '0;
          ovf_nxt = 1'b0;
          if (in_byte == LEN64_CODE) begin
            left_nxt  = LEN64_BYTES;
            phase_nxt = PH_LEN;
          end else if (in_byte == LEN16_CODE) begin
            left_nxt  = LEN16_BYTES;
            phase_nxt = PH_LEN;
          end else begin
            payload_nxt = chk_len;
            key_nxt     = '0;
            idx_nxt     = '0;
            phase_nxt   = PH_MASK;
          end
        end
        PH_LEN: begin
          acc_nxt  = acc_shift;
          ovf_nxt  = ovf_shift;
          left_nxt = left_dec;
          if (len_last) begin
            payload_nxt = chk_len;
            key_nxt     = '0;
            idx_nxt     = '0;
            phase_nxt   = PH_MASK;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_byte};
          idx_nxt = idx_r + 1'b1;
          if (mask_done) begin
            phase_nxt = (payload_r == '0) ? PH_HDR0 : PH_DATA;
          end
        end
        PH_DATA: begin
          idx_nxt = idx_r + 1'b1;
          if (payload_r != '0) begin
            payload_nxt = payload_r - 1'b1;
          end
          if (data_last) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: phase_nxt = PH_HDR0;
      endcase
    end
  end

  // result
  always_comb begin
    res = '{valid: 1'b0, kind: KIND_DATA, data: 8'h00, last: 1'b0, err: ERR_NONE};
    priority if (err_first) begin
      res.valid = 1'b1;
      res.kind  = KIND_ERROR;
      res.err   = ERR_FIRST;
    end else if (err_nomask) begin
      res.valid = 1'b1;
      res.kind  = KIND_ERROR;
      res.err   = ERR_NOMASK;
    end else if (err_long) begin
      res.valid = 1'b1;
      res.kind  = KIND_ERROR;
      res.err   = ERR_LONG;
    end else if (act && (phase_r == PH_MASK) && mask_done && (payload_r == '0)) begin
      res.valid = 1'b1;
      res.kind  = KIND_EMPTY;
      res.last  = 1'b1;
    end else if (act && (phase_r == PH_DATA)) begin
      res.valid = 1'b1;
      res.kind  = KIND_DATA;
      res.data  = in_byte ^ key_byte;
      res.last  = data_last;
    end else begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      left_r    <= '0;
      payload_r <= '0;
      key_r     <= '0;
      idx_r     <= '0;
      halted_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      ovf_r     <= ovf_nxt;
      left_r    <= left_nxt;
      payload_r <= payload_nxt;
      key_r     <= key_nxt;
      idx_r     <= idx_nxt;
      halted_r  <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/wsfr_checker.sv =====
// Port-level checks of the websocket frame receiver, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module wsfr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire  [7:0] out_tdata,
  input wire  [3:0] out_tuser,
  input wire        out_tlast
);
  import wsfr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  // error results carry no byte, no frame end, and a nonzero code
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == KIND_ERROR) |->
      !out_tlast && (out_tdata == 8'h00) && (out_tuser[3:2] != ERR_NONE))
    else $error("malformed error result");

  // empty frame and payload results: no error code; empty frame ends a frame with no data
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != KIND_ERROR) |->
      (out_tuser[3:2] == ERR_NONE) &&
      ((out_tuser[1:0] == KIND_DATA) || (out_tuser[1:0] == KIND_EMPTY)) &&
      ((out_tuser[1:0] != KIND_EMPTY) || (out_tlast && (out_tdata == 8'h00))))
    else $error("malformed data or empty-frame result");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with output free");

endmodule

bind websocket_frame_receiver_core wsfr_checker u_wsfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
